FILE: design/ring_buffer_deque_macros.svh
// Assertion macros for the ring buffer deque.
// Used by ring_buffer_deque.sv; expects clk and arst_n in scope.
`ifndef RING_BUFFER_DEQUE_MACROS_SVH
`define RING_BUFFER_DEQUE_MACROS_SVH

// Condition must hold on every rising clock edge outside reset.
`define RBD_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define RBD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RBD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/rbd_pkg.sv
// Shared types and fixed field widths for the ring buffer deque.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package rbd_pkg;

	localparam int ACTION_W = 3;
	localparam int VALUE_W  = 32;
	localparam int INDEX_W  = 5;
	localparam int COUNT_W  = 5;
	localparam int STATUS_W = 2;

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUSH_FRONT = 3'd0,
		ACT_PUSH_BACK  = 3'd1,
		ACT_POP_FRONT  = 3'd2,
		ACT_POP_BACK   = 3'd3,
		ACT_READ       = 3'd4,
		ACT_WRITE      = 3'd5,
		ACT_SWAP       = 3'd6
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// Swap write-back sequencer: one memory write per phase.
	typedef enum logic [1:0] {
		SWP_IDLE,
		SWP_FIRST,
		SWP_SECOND
	} swap_state_t;

endpackage

`default_nettype wire

FILE: design/rbd_cmd_if.sv
// Request channel of the ring buffer deque: valid/ready plus operation fields.
// Depends on rbd_pkg for the field widths.
`default_nettype none

interface rbd_cmd_if;
	import rbd_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [ACTION_W-1:0]        action;
	logic [VALUE_W-1:0]         value;
	logic signed [INDEX_W-1:0]  index_a;
	logic signed [INDEX_W-1:0]  index_b;

	modport source (output valid, action, value, index_a, index_b, input ready);
	modport sink   (input valid, action, value, index_a, index_b, output ready);
endinterface

`default_nettype wire

FILE: design/rbd_result_if.sv
// Result channel of the ring buffer deque: valid/ready plus result fields.
// Depends on rbd_pkg for the field widths.
`default_nettype none

interface rbd_result_if;
	import rbd_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [VALUE_W-1:0]   read_value;
	logic [COUNT_W-1:0]   entry_count;
	logic                 is_empty;
	logic                 is_full;
	logic [STATUS_W-1:0]  status;

	modport source (output valid, read_value, entry_count, is_empty, is_full, status,
		input ready);
	modport sink   (input valid, read_value, entry_count, is_empty, is_full, status,
		output ready);
endinterface

`default_nettype wire

FILE: design/ring_buffer_deque.sv
// Ring buffer deque: DEPTH-entry double-ended queue with indexed read, write and swap.
// Most requests are taken one per cycle while the result side keeps up; after a
// successful swap, ready is held low while the single memory write port stores the
// two exchanged entries in turn. Each result passes the memory read register, then
// the output register. While a result waits at the output, one more request can
// still enter stage 1, but the next one waits until the output moves on. The store
// is not cleared after reset, so the block is ready at once. Depends on rbd_pkg,
// rbd_cmd_if, rbd_result_if and ring_buffer_deque_macros.svh.
`default_nettype none

`include "ring_buffer_deque_macros.svh"

module ring_buffer_deque #(
	parameter int DEPTH  = 16,
	parameter int DATA_W = 32
) (
	input  wire            clk,
	input  wire            arst_n,
	rbd_cmd_if.sink        cmd,
	rbd_result_if.source   result
);
	import rbd_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = ((CW > INDEX_W) ? CW : INDEX_W) + 1;
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [AW:0]   DEPTH_X   = (AW + 1)'(DEPTH);
	localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

	// Control state
	logic [AW-1:0] head_q, tail_q, head_d, tail_d;
	logic [CW-1:0] count_q, count_d;
	swap_state_t   swap_state_q, swap_state_d;
	logic [AW-1:0] swap_a_q, swap_b_q;

	// Store and its registered read ports
	logic [DATA_W-1:0] ring_q [DEPTH];
	logic [DATA_W-1:0] rd_a_s1, rd_b_s1;

	// Stage 1 and output register
	logic               valid_s1, rd_sel_s1;
	logic [CW-1:0]      count_s1;
	status_t            status_s1;
	logic               adv_s1;
	logic               out_valid_q;
	logic [VALUE_W-1:0] out_value_q;
	logic [COUNT_W-1:0] out_count_q;
	logic               out_empty_q, out_full_q;
	status_t            out_status_q;

	// Decode
	logic          accept;
	logic          ok_a, ok_b;
	logic [AW-1:0] slot_a, slot_b;
	logic          wr_req, rd_ok, swap_ok;
	logic [AW-1:0] wr_addr;
	status_t       status_d;

	// Memory write port
	logic              mem_we;
	logic [AW-1:0]     mem_addr;
	logic [DATA_W-1:0] mem_data;

	// Map a logical index to {in range, physical slot}.
	function automatic logic [AW:0] resolve(
		input logic [INDEX_W-1:0] idx,
		input logic [CW-1:0]      cnt,
		input logic [AW-1:0]      head
	);
		logic [IW-1:0] idx_x;
		logic [IW-1:0] cnt_x;
		logic [IW-1:0] pos;
		logic          in_range;
		logic [AW:0]   sum;
		logic [AW-1:0] slot;
		idx_x = {{(IW - INDEX_W){idx[INDEX_W-1]}}, idx};
		cnt_x = {{(IW - CW){1'b0}}, cnt};
		// negative index counts back from the back entry, so -1 names the tail
		pos = idx_x + (idx_x[IW-1] ? cnt_x : '0);
		in_range = !pos[IW-1] && (pos < cnt_x);
		sum = {1'b0, head} + {1'b0, pos[AW-1:0]};
		slot = (sum >= DEPTH_X) ? AW'(sum - DEPTH_X) : sum[AW-1:0];
		return {in_range, slot};
	endfunction

	assign accept    = cmd.valid && cmd.ready;
	assign adv_s1    = !out_valid_q || result.ready;
	assign cmd.ready = (!valid_s1 || adv_s1) && (swap_state_q == SWP_IDLE);

	assign {ok_a, slot_a} = resolve(cmd.index_a, count_q, head_q);
	assign {ok_b, slot_b} = resolve(cmd.index_b, count_q, head_q);

	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		count_d  = count_q;
		status_d = ST_OK;
		wr_req   = 1'b0;
		wr_addr  = slot_a;
		rd_ok    = 1'b0;
		swap_ok  = 1'b0;
		unique case (cmd.action) inside
			ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
				if (count_q == FULL_CNT) begin
					status_d = ST_FULL;
				end else begin
					wr_req  = 1'b1;
					count_d = CW'(count_q + 1'b1);
					if (count_q == '0) begin
						head_d  = '0;
						tail_d  = '0;
						wr_addr = '0;
					end else if (cmd.action == ACT_PUSH_FRONT) begin
						head_d  = (head_q == '0) ? LAST_SLOT : AW'(head_q - 1'b1);
						wr_addr = head_d;
					end else begin
						tail_d  = (tail_q == LAST_SLOT) ? '0 : AW'(tail_q + 1'b1);
						wr_addr = tail_d;
					end
				end
			end
			ACT_POP_FRONT, ACT_POP_BACK: begin
				if (count_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					count_d = CW'(count_q - 1'b1);
					if (count_d == '0) begin
						head_d = '0;
						tail_d = '0;
					end else if (cmd.action == ACT_POP_FRONT) begin
						head_d = (head_q == LAST_SLOT) ? '0 : AW'(head_q + 1'b1);
					end else begin
						tail_d = (tail_q == '0) ? LAST_SLOT : AW'(tail_q - 1'b1);
					end
				end
			end
			ACT_READ: begin
				if (ok_a) rd_ok = 1'b1;
				else status_d = ST_RANGE;
			end
			ACT_WRITE: begin
				if (ok_a) wr_req = 1'b1;
				else status_d = ST_RANGE;
			end
			ACT_SWAP: begin
				if (ok_a && ok_b) swap_ok = 1'b1;
				else status_d = ST_RANGE;
			end
			default: begin
			end
		endcase
	end

	// Swap sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_state_q <= SWP_IDLE;
		end else begin
			swap_state_q <= swap_state_d;
		end
	end

	always_comb begin
		swap_state_d = swap_state_q;
		mem_we       = accept && wr_req;
		mem_addr     = wr_addr;
		mem_data     = DATA_W'(cmd.value);
		unique case (swap_state_q)
			SWP_IDLE: begin
				if (accept && swap_ok) swap_state_d = SWP_FIRST;
			end
			SWP_FIRST: begin
				mem_we       = 1'b1;
				mem_addr     = swap_a_q;
				mem_data     = rd_b_s1;
				swap_state_d = SWP_SECOND;
			end
			SWP_SECOND: begin
				mem_we       = 1'b1;
				mem_addr     = swap_b_q;
				mem_data     = rd_a_s1;
				swap_state_d = SWP_IDLE;
			end
			default: begin
				swap_state_d = SWP_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			swap_a_q <= slot_a;
			swap_b_q <= slot_b;
		end
	end

	// Store: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (mem_we) ring_q[mem_addr] <= mem_data;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_a_s1 <= ring_q[slot_a];
			rd_b_s1 <= ring_q[slot_b];
		end
	end

	// Stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_sel_s1 <= rd_ok;
			count_s1  <= count_d;
			status_s1 <= status_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			out_value_q  <= rd_sel_s1 ? VALUE_W'(rd_a_s1) : '0;
			out_count_q  <= COUNT_W'(count_s1);
			out_empty_q  <= (count_s1 == '0);
			out_full_q   <= (count_s1 == FULL_CNT);
			out_status_q <= status_s1;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.read_value  = out_value_q;
	assign result.entry_count = out_count_q;
	assign result.is_empty    = out_empty_q;
	assign result.is_full     = out_full_q;
	assign result.status      = out_status_q;

	// Tail must sit count-1 slots past the head whenever entries are held.
	logic [AW:0]   tail_sum;
	logic [AW-1:0] tail_exp;
	logic          push_take;
	logic [CW-1:0] count_up;
	logic          swap_take;
	logic          swap_hold;
	assign tail_sum = {1'b0, head_q} + {1'b0, AW'(count_q - 1'b1)};
	assign tail_exp = (tail_sum >= DEPTH_X) ? AW'(tail_sum - DEPTH_X) : tail_sum[AW-1:0];
	assign push_take = accept && (count_q != FULL_CNT)
		&& (cmd.action == ACT_PUSH_FRONT || cmd.action == ACT_PUSH_BACK);
	assign count_up  = CW'(count_q + 1'b1);
	assign swap_take = accept && swap_ok;
	assign swap_hold = !cmd.ready && (swap_state_q == SWP_FIRST);

	`RBD_ASSERT_ALWAYS(a_count_bound, count_q <= FULL_CNT, "entry count above depth")
	`RBD_ASSERT_SAME(a_tail_track, count_q != '0, tail_q == tail_exp, "tail lost track of head")
	`RBD_ASSERT_NEXT(a_push_count, push_take, count_q == $past(count_up), "push missed count")
	`RBD_ASSERT_NEXT(a_swap_stall, swap_take, swap_hold, "request taken during swap write-back")

endmodule

`default_nettype wire

FILE: tb/tb_ring_buffer_deque.sv
`timescale 1ns / 100ps
// Testbench for ring_buffer_deque: directed, backpressure and random request streams.
// Compares each result with a cycle-free deque predictor. Needs rbd_pkg, rbd_cmd_if,
// rbd_result_if and the block itself.

module tb_ring_buffer_deque;
	import rbd_pkg::*;

	localparam int DEPTH       = 16;
	localparam int CYCLE_LIMIT = 100000;

	typedef struct {
		logic [VALUE_W-1:0] read_value;
		logic [COUNT_W-1:0] entry_count;
		logic               is_empty;
		logic               is_full;
		status_t            status;
	} deque_result_t;

	logic clk;
	logic arst_n;

	rbd_cmd_if    cmd_ch ();
	rbd_result_if res_ch ();

	ring_buffer_deque #(.DEPTH(DEPTH), .DATA_W(VALUE_W)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.result (res_ch)
	);

	// Predicted deque contents and the results still owed by the block.
	logic [VALUE_W-1:0] shadow_store [DEPTH];
	logic [3:0]         shadow_head;
	logic [3:0]         shadow_tail;
	int                 shadow_count;
	deque_result_t      pending_results [$];

	int errors;
	int hold_left;
	int cycle_count;
	bit src_idle_on;
	bit sink_idle_on;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Map a logical index to a slot; false when outside the held entries.
	function automatic bit locate_entry(logic signed [INDEX_W-1:0] idx, output logic [3:0] slot);
		int pos;
		pos = int'(idx);
		if (pos < 0)
			pos += shadow_count;
		slot = shadow_head + pos[3:0];
		return (pos >= 0) && (pos < shadow_count);
	endfunction

	function automatic deque_result_t apply_request(action_t act, logic [VALUE_W-1:0] val,
		logic signed [INDEX_W-1:0] ia, logic signed [INDEX_W-1:0] ib);
		deque_result_t r;
		logic [3:0] sa;
		logic [3:0] sb;
		logic [VALUE_W-1:0] tmp;
		r.read_value = '0;
		r.status = ST_OK;
		case (act)
			ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
				if (shadow_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					if (shadow_count == 0) begin
						shadow_head = '0;
						shadow_tail = '0;
						shadow_store[0] = val;
					end else if (act == ACT_PUSH_FRONT) begin
						shadow_head = shadow_head - 4'd1;
						shadow_store[shadow_head] = val;
					end else begin
						shadow_tail = shadow_tail + 4'd1;
						shadow_store[shadow_tail] = val;
					end
					shadow_count++;
				end
			end
			ACT_POP_FRONT, ACT_POP_BACK: begin
				if (shadow_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					shadow_count--;
					if (shadow_count == 0) begin
						shadow_head = '0;
						shadow_tail = '0;
					end else if (act == ACT_POP_FRONT) begin
						shadow_head = shadow_head + 4'd1;
					end else begin
						shadow_tail = shadow_tail - 4'd1;
					end
				end
			end
			ACT_READ: begin
				if (locate_entry(ia, sa))
					r.read_value = shadow_store[sa];
				else
					r.status = ST_RANGE;
			end
			ACT_WRITE: begin
				if (locate_entry(ia, sa))
					shadow_store[sa] = val;
				else
					r.status = ST_RANGE;
			end
			ACT_SWAP: begin
				if (locate_entry(ia, sa) && locate_entry(ib, sb)) begin
					tmp = shadow_store[sa];
					shadow_store[sa] = shadow_store[sb];
					shadow_store[sb] = tmp;
				end else begin
					r.status = ST_RANGE;
				end
			end
			default: ;
		endcase
		r.entry_count = shadow_count[COUNT_W-1:0];
		r.is_empty = (shadow_count == 0);
		r.is_full = (shadow_count == DEPTH);
		return r;
	endfunction

	// Offer one request; record its result once the block takes it.
	task automatic send_request(action_t act, logic [VALUE_W-1:0] val,
		logic signed [INDEX_W-1:0] ia, logic signed [INDEX_W-1:0] ib);
		while (src_idle_on && $urandom_range(99) < 32) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.action <= act;
		cmd_ch.value <= val;
		cmd_ch.index_a <= ia;
		cmd_ch.index_b <= ib;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		pending_results.push_back(apply_request(act, val, ia, ib));
		@(negedge clk);
	endtask

	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// Mostly an index inside the held range, in either notation.
	function automatic logic signed [INDEX_W-1:0] pick_index();
		int pos;
		if (shadow_count == 0 || $urandom_range(99) < 15)
			return INDEX_W'($urandom_range(31));
		pos = $urandom_range(shadow_count - 1);
		if ($urandom_range(1))
			pos -= shadow_count;
		return INDEX_W'(pos);
	endfunction

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_directed();
		send_request(ACT_POP_FRONT, '0, 0, 0);
		send_request(ACT_POP_BACK, '0, 0, 0);
		send_request(ACT_READ, '0, 0, 0);
		send_request(ACT_SWAP, '0, 0, 0);
		send_request(ACT_WRITE, 32'h0bad_f00d, 0, 0);
		// first push into an empty store, then wrap the head below slot zero
		send_request(ACT_PUSH_FRONT, 32'h0000_0000, 0, 0);
		send_request(ACT_PUSH_FRONT, 32'hffff_ffff, 0, 0);
		send_request(ACT_PUSH_BACK, 32'haaaa_aaaa, 0, 0);
		send_request(ACT_PUSH_BACK, 32'h5555_5555, 0, 0);
		send_request(ACT_READ, '0, 0, 0);
		send_request(ACT_READ, '0, -1, 0);
		send_request(ACT_READ, '0, -16, 0);
		send_request(ACT_READ, '0, 15, 0);
		send_request(ACT_READ, '0, -4, 0);
		send_request(ACT_WRITE, 32'h1234_5678, 1, 0);
		send_request(ACT_WRITE, 32'hdead_beef, -1, 0);
		send_request(ACT_SWAP, '0, 0, -1);
		send_request(ACT_READ, '0, 0, 0);
		send_request(ACT_READ, '0, 3, 0);
		send_request(ACT_SWAP, '0, 1, 4);
		send_request(ACT_POP_BACK, '0, 0, 0);
		send_request(ACT_POP_FRONT, '0, 0, 0);
		send_request(ACT_POP_FRONT, '0, 0, 0);
		// last entry leaves: head and tail return to slot zero
		send_request(ACT_POP_BACK, '0, 0, 0);
	endtask

	// Stall the result side long enough that the block backs up into its input.
	task automatic test_backpressure();
		hold_left = 80;
		repeat (20)
			send_request($urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT, pick_value(), 0, 0);
		wait_drained();
	endtask

	task automatic test_random(int count, int push_pct, int pop_pct, bit idle);
		int r;
		src_idle_on = idle;
		sink_idle_on = idle;
		repeat (count) begin
			r = $urandom_range(99);
			if (r < push_pct)
				send_request($urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT,
					pick_value(), pick_index(), pick_index());
			else if (r < push_pct + pop_pct)
				send_request($urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT,
					pick_value(), pick_index(), pick_index());
			else
				case ($urandom_range(2))
					0: send_request(ACT_READ, pick_value(), pick_index(), pick_index());
					1: send_request(ACT_WRITE, pick_value(), pick_index(), pick_index());
					default: send_request(ACT_SWAP, pick_value(), pick_index(), pick_index());
				endcase
		end
		src_idle_on = 1'b1;
		sink_idle_on = 1'b1;
	endtask

	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				res_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				res_ch.ready <= !(sink_idle_on && $urandom_range(99) < 32);
			end
		end
	end

	always @(posedge clk) begin
		deque_result_t want;
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("result with no pending request");
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (res_ch.read_value !== want.read_value) begin
					$error("read_value expected %h got %h", want.read_value, res_ch.read_value);
					errors++;
				end
				if (res_ch.entry_count !== want.entry_count) begin
					$error("entry_count expected %0d got %0d", want.entry_count,
						res_ch.entry_count);
					errors++;
				end
				if (res_ch.is_empty !== want.is_empty) begin
					$error("is_empty expected %b got %b", want.is_empty, res_ch.is_empty);
					errors++;
				end
				if (res_ch.is_full !== want.is_full) begin
					$error("is_full expected %b got %b", want.is_full, res_ch.is_full);
					errors++;
				end
				if (res_ch.status !== want.status) begin
					$error("status expected %0d got %0d", want.status, res_ch.status);
					errors++;
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.action = '0;
		cmd_ch.value = '0;
		cmd_ch.index_a = '0;
		cmd_ch.index_b = '0;
		errors = 0;
		hold_left = 0;
		src_idle_on = 1'b1;
		sink_idle_on = 1'b1;
		shadow_head = '0;
		shadow_tail = '0;
		shadow_count = 0;
		foreach (shadow_store[i])
			shadow_store[i] = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_backpressure();
		test_random(150, 60, 20, 1'b1);
		test_random(150, 35, 35, 1'b0);
		test_random(150, 20, 60, 1'b1);
		test_random(200, 40, 30, 1'b1);

		wait_drained();
		repeat (10) @(negedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
